FILE: design/eacc_pkg.sv
// ----------------------------------------------------------------------------
// eacc_pkg: shared types and constants
// Phase codes, bus access codes, transaction modes and configuration indexes.
// ----------------------------------------------------------------------------
package eacc_pkg;

   localparam int STACK_DEPTH  = 8;
   localparam int STACK_BITS   = $clog2(STACK_DEPTH);
   localparam int ADDRESS_BITS = 14;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_FETCH  = 4'd1,
      PH_OPER1  = 4'd2,
      PH_OPER2  = 4'd3,
      PH_MREAD  = 4'd4,
      PH_MWRITE = 4'd5,
      PH_IN     = 4'd6,
      PH_OUT    = 4'd7
   } phase_type;

   typedef enum logic [2:0] {
      ACC_MEM_READ  = 3'd0,
      ACC_MEM_WRITE = 3'd1,
      ACC_IO_INPUT  = 3'd2,
      ACC_IO_OUTPUT = 3'd3,
      ACC_IDLE      = 3'd4
   } access_type;

   localparam logic [1:0] MODE_COMPLETE = 2'd0;
   localparam logic [1:0] MODE_JAM      = 2'd1;
   localparam logic [1:0] MODE_RESUME   = 2'd2;

   localparam logic CSR_BREAKPOINT  = 1'b0;
   localparam logic CSR_SINGLE_STEP = 1'b1;

   // even parity of a byte
   function automatic logic even_parity(input logic [7:0] v);
      even_parity = ~(^v);
   endfunction

endpackage

FILE: design/eight_bit_accumulator_cpu_core_top.sv
// ----------------------------------------------------------------------------
// eight_bit_accumulator_cpu_core_top: bus-stepped 8-bit accumulator cpu core
// Each request transaction completes a bus access, jams an interrupt
// instruction or resumes from halt; each response is the next bus request.
// ----------------------------------------------------------------------------
// On acceptance of a request transaction the core updates its
// registers, stack and phase in a single pass and registers the next bus
// request into a one-entry response register, so one transaction per cycle
// is sustained while responses are taken; a request is still accepted while
// the response register holds an untaken response as long as that response
// is taken in the same cycle. The response appears in the cycle after its
// request is accepted. Return stack and register file are flip-flops cleared by reset.
module eight_bit_accumulator_cpu_core_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_mode,
   input  logic [7:0]                          req_read_data,
   input  logic [7:0]                          req_jam_first,
   input  logic [7:0]                          req_jam_second,
   input  logic [7:0]                          req_jam_third,
   input  logic [1:0]                          req_jam_count,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_access,
   output logic [eacc_pkg::ADDRESS_BITS-1:0]   rsp_address,
   output logic [7:0]                          rsp_write_data,
   output logic                                rsp_opcode_fetch,
   output logic                                rsp_instruction_done,
   output logic [3:0]                          rsp_states_used,
   output logic [3:0]                          rsp_condition_flags,
   output logic [15:0]                         rsp_program_counter,
   input  logic                                csr_write,
   input  logic                                csr_index,
   input  logic [15:0]                         csr_data
);
   import eacc_pkg::*;

   // architectural state
   logic [15:0]           stack_ff [STACK_DEPTH];
   logic [15:0]           stack_in [STACK_DEPTH];
   logic [STACK_BITS-1:0] sp_ff, sp_in;
   logic [7:0]            regs_ff [7];
   logic [7:0]            regs_in [7];
   logic [3:0]            flags_ff, flags_in;
   logic                  halted_ff, halted_in;
   logic [7:0]            jam_ff [3];
   logic [7:0]            jam_in [3];
   logic [1:0]            jam_pos_ff, jam_pos_in;
   logic [1:0]            jam_len_ff, jam_len_in;
   logic                  jam_act_ff, jam_act_in;
   logic [7:0]            opcode_ff, opcode_in;
   logic [15:0]           operand_ff, operand_in;
   phase_type             phase_ff, phase_in;
   logic [15:0]           bkpt_ff;
   logic                  sstep_ff;

   // response register
   logic                  rsp_valid_ff;
   logic [2:0]            acc_ff, acc_in;
   logic [ADDRESS_BITS-1:0] addr_ff, addr_in;
   logic [7:0]            wd_ff, wd_in;
   logic                  fetch_ff, fetch_in;
   logic                  done_ff, done_in;
   logic [3:0]            states_ff, states_in;
   logic [3:0]            rflags_ff;
   logic [15:0]           rpc_ff, rpc_in;

   logic accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bkpt_ff  <= 16'hFFFF;
         sstep_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BREAKPOINT:  bkpt_ff  <= csr_data;
            CSR_SINGLE_STEP: sstep_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // one instruction step
   always_comb begin
      logic [7:0]  op, a, s, rv;
      logic [8:0]  r;
      logic [2:0]  dst, src, rr, low;
      logic [1:0]  have, need, n;
      logic        c, fin, store, cond, go;
      logic [3:0]  cyc, scyc;
      logic [15:0] pc, sv;
      logic [7:0]  stv;
      logic        alu_go;
      logic [2:0]  alu_kind;
      logic [7:0]  alu_src;

      stack_in   = stack_ff;
      sp_in      = sp_ff;
      regs_in    = regs_ff;
      flags_in   = flags_ff;
      halted_in  = halted_ff;
      jam_in     = jam_ff;
      jam_pos_in = jam_pos_ff;
      jam_len_in = jam_len_ff;
      jam_act_in = jam_act_ff;
      opcode_in  = opcode_ff;
      operand_in = operand_ff;
      phase_in   = phase_ff;
      done_in    = 1'b0;
      states_in  = 4'd0;
      fin   = 1'b0;
      cyc   = 4'd0;
      store = 1'b0;
      stv   = 8'd0;
      scyc  = 4'd0;
      alu_go   = 1'b0;
      alu_kind = 3'd0;
      alu_src  = 8'd0;
      have  = 2'd0;
      go    = 1'b0;
      pc    = stack_ff[sp_ff];
      op    = opcode_ff;
      a = 8'd0; s = 8'd0; rv = 8'd0; r = 9'd0; dst = 3'd0; src = 3'd0;
      rr = 3'd0; low = 3'd0; need = 2'd0; n = 2'd0; c = 1'b0; cond = 1'b0;
      sv = 16'd0;

      // bus completion, jam entry or resume from halt
      if (req_mode == MODE_COMPLETE) begin
         unique case (phase_ff)
            PH_FETCH: begin
               if (pc == bkpt_ff) halted_in = 1'b1;
               stack_in[sp_ff] = pc + 16'd1;
               op = req_read_data; opcode_in = op; operand_in = 16'd0;
               have = 2'd0; go = 1'b1;
            end
            PH_OPER1: begin
               operand_in = operand_ff | {8'd0, req_read_data};
               stack_in[sp_ff] = pc + 16'd1;
               have = 2'd1; go = 1'b1;
            end
            PH_OPER2: begin
               operand_in = operand_ff | {req_read_data, 8'd0};
               stack_in[sp_ff] = pc + 16'd1;
               have = 2'd2; go = 1'b1;
            end
            PH_MREAD: begin
               if (op[7:6] == 2'd3) begin
                  store = 1'b1; stv = req_read_data; scyc = 4'd8;
               end else begin
                  alu_go = 1'b1; alu_kind = op[5:3]; alu_src = req_read_data;
                  fin = 1'b1; cyc = 4'd8;
               end
            end
            PH_MWRITE: begin
               fin = 1'b1; cyc = (op[7:6] == 2'd3) ? 4'd7 : 4'd9;
            end
            PH_IN: begin
               regs_in[0] = req_read_data; fin = 1'b1; cyc = 4'd8;
            end
            PH_OUT: begin
               fin = 1'b1; cyc = 4'd5;
            end
            default: ;
         endcase
      end else if (req_mode == MODE_JAM) begin
         if (phase_ff == PH_IDLE || phase_ff == PH_FETCH) begin
            n = (req_jam_count == 2'd0) ? 2'd1 : req_jam_count;
            jam_in[0] = req_jam_first;
            jam_in[1] = req_jam_second;
            jam_in[2] = req_jam_third;
            jam_len_in = n;
            halted_in  = 1'b0;
            jam_pos_in = 2'd1;
            jam_act_in = (n > 2'd1);
            op = req_jam_first; opcode_in = op; operand_in = 16'd0;
            have = 2'd0; go = 1'b1;
         end
      end else if (req_mode == MODE_RESUME) begin
         if (phase_ff == PH_IDLE) begin
            halted_in = 1'b0;
            phase_in  = PH_FETCH;
         end
      end

      // operand gathering (at most two bytes from the jam) and execution
      if (go) begin
         if (op[7:6] == 2'd0 && (op[2:0] == 3'd4 || op[2:0] == 3'd6)) need = 2'd1;
         else if (op[7:6] == 2'd1 && !op[0]) need = 2'd2;
         else need = 2'd0;
         if (have < need && jam_act_in) begin
            operand_in = operand_in | (have[0] ? {jam_in[jam_pos_in], 8'd0}
                                               : {8'd0, jam_in[jam_pos_in]});
            jam_pos_in = jam_pos_in + 2'd1;
            if (jam_pos_in >= jam_len_in) jam_act_in = 1'b0;
            have = have + 2'd1;
         end
         if (have < need && jam_act_in) begin
            operand_in = operand_in | {jam_in[jam_pos_in], 8'd0};
            jam_pos_in = jam_pos_in + 2'd1;
            if (jam_pos_in >= jam_len_in) jam_act_in = 1'b0;
            have = have + 2'd1;
         end
         if (have < need) begin
            phase_in = (have != 2'd0) ? PH_OPER2 : PH_OPER1;
         end else begin
            src = op[2:0];
            rr  = op[5:3];
            low = op[2:0];
            cond = flags_ff[op[4:3]] == op[5];
            unique case (op[7:6])
               2'd3: begin
                  if (op == 8'hFF) begin
                     halted_in = 1'b1; fin = 1'b1; cyc = 4'd9;
                  end else if (src == 3'd7) phase_in = PH_MREAD;
                  else begin
                     store = 1'b1; stv = regs_ff[src]; scyc = 4'd5;
                  end
               end
               2'd2: begin
                  if (src == 3'd7) phase_in = PH_MREAD;
                  else begin
                     alu_go = 1'b1; alu_kind = op[5:3]; alu_src = regs_ff[src];
                     fin = 1'b1; cyc = 4'd5;
                  end
               end
               2'd1: begin
                  if (op[0]) begin
                     phase_in = (op[5:4] == 2'd0) ? PH_IN : PH_OUT;
                  end else begin
                     cyc = 4'd9;
                     if (op[2] || cond) begin
                        if (op[1]) begin
                           sp_in = sp_ff + STACK_BITS'(1); cyc = 4'd11;
                        end
                        stack_in[sp_in] = operand_in;
                     end
                     fin = 1'b1;
                  end
               end
               default: begin
                  if (low < 3'd2) begin
                     if (rr == 3'd0) begin
                        halted_in = 1'b1; fin = 1'b1; cyc = 4'd4;
                     end else begin
                        if (rr != 3'd7) begin
                           rv = regs_ff[rr] + (low[0] ? 8'hFF : 8'h01);
                           regs_in[rr] = rv;
                           flags_in = {even_parity(rv), rv[7], rv == 8'd0, flags_ff[0]};
                        end
                        fin = 1'b1; cyc = 4'd5;
                     end
                  end else if (low == 3'd2) begin
                     a = regs_ff[0]; c = flags_ff[0];
                     rv = a; s[0] = c;
                     case (op)
                        8'o002: begin rv = {a[6:0], a[7]}; s[0] = a[7]; end
                        8'o012: begin rv = {a[0], a[7:1]}; s[0] = a[0]; end
                        8'o022: begin rv = {a[6:0], c};    s[0] = a[7]; end
                        8'o032: begin rv = {c, a[7:1]};    s[0] = a[0]; end
                        default: ;
                     endcase
                     regs_in[0] = rv;
                     flags_in = {flags_ff[3:1], s[0]};
                     fin = 1'b1; cyc = 4'd5;
                  end else if (low[1:0] == 2'd3) begin
                     if (op[2] || cond) begin
                        sp_in = sp_ff - STACK_BITS'(1); cyc = 4'd5;
                     end else cyc = 4'd3;
                     fin = 1'b1;
                  end else if (low == 3'd4) begin
                     alu_go = 1'b1; alu_kind = rr; alu_src = operand_in[7:0];
                     fin = 1'b1; cyc = 4'd8;
                  end else if (low == 3'd5) begin
                     sp_in = sp_ff + STACK_BITS'(1);
                     stack_in[sp_in] = {10'd0, op[5:3], 3'd0};
                     fin = 1'b1; cyc = 4'd5;
                  end else begin
                     store = 1'b1; stv = operand_in[7:0]; scyc = 4'd8;
                  end
               end
            endcase
         end
      end

      // alu operation on the accumulator
      if (alu_go) begin
         a = regs_ff[0]; c = flags_ff[0];
         case (alu_kind)
            3'd0: r = {1'b0, a} + {1'b0, alu_src};
            3'd1: r = {1'b0, a} + {1'b0, alu_src} + {8'd0, c};
            3'd2: r = {1'b0, a} - {1'b0, alu_src};
            3'd3: r = {1'b0, a} - {1'b0, alu_src} - {8'd0, c};
            3'd4: r = {1'b0, a & alu_src};
            3'd5: r = {1'b0, a ^ alu_src};
            3'd6: r = {1'b0, a | alu_src};
            default: r = {1'b0, a} - {1'b0, alu_src};
         endcase
         if (alu_kind != 3'd7) regs_in[0] = r[7:0];
         flags_in = {even_parity(r[7:0]), r[7], r[7:0] == 8'd0, r[8]};
      end

      // register or memory destination
      if (store) begin
         dst = op[5:3];
         if (dst == 3'd7) begin
            operand_in = {8'd0, stv};
            phase_in   = PH_MWRITE;
         end else begin
            regs_in[dst] = stv;
            fin = 1'b1; cyc = scyc;
         end
      end

      // instruction end
      if (fin) begin
         done_in    = 1'b1;
         states_in  = cyc;
         jam_act_in = 1'b0;
         if (sstep_ff) halted_in = 1'b1;
         phase_in = halted_in ? PH_IDLE : PH_FETCH;
      end

      // next bus request
      sv = stack_in[sp_in];
      acc_in = ACC_IDLE; addr_in = '0; wd_in = 8'd0;
      unique case (phase_in)
         PH_FETCH, PH_OPER1, PH_OPER2: begin
            acc_in = ACC_MEM_READ; addr_in = sv[ADDRESS_BITS-1:0];
         end
         PH_MREAD: begin
            acc_in = ACC_MEM_READ; addr_in = {regs_in[5][5:0], regs_in[6]};
         end
         PH_MWRITE: begin
            acc_in = ACC_MEM_WRITE; addr_in = {regs_in[5][5:0], regs_in[6]};
            wd_in = operand_in[7:0];
         end
         PH_IN: begin
            acc_in = ACC_IO_INPUT; addr_in = {9'd0, opcode_in[5:1]};
         end
         PH_OUT: begin
            acc_in = ACC_IO_OUTPUT; addr_in = {9'd0, opcode_in[5:1]};
            wd_in = regs_in[0];
         end
         default: ;
      endcase
      fetch_in = (phase_in == PH_FETCH);
      rpc_in   = sv;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STACK_DEPTH; i++) stack_ff[i] <= 16'd0;
         for (int i = 0; i < 7; i++) regs_ff[i] <= 8'd0;
         sp_ff      <= '0;
         flags_ff   <= 4'd0;
         halted_ff  <= 1'b1;
         jam_pos_ff <= 2'd0;
         jam_len_ff <= 2'd0;
         jam_act_ff <= 1'b0;
         opcode_ff  <= 8'd0;
         operand_ff <= 16'd0;
         phase_ff   <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            stack_ff   <= stack_in;
            regs_ff    <= regs_in;
            sp_ff      <= sp_in;
            flags_ff   <= flags_in;
            halted_ff  <= halted_in;
            jam_pos_ff <= jam_pos_in;
            jam_len_ff <= jam_len_in;
            jam_act_ff <= jam_act_in;
            opcode_ff  <= opcode_in;
            operand_ff <= operand_in;
            phase_ff   <= phase_in;
         end
         if (accept) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // jam bytes and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         jam_ff    <= jam_in;
         acc_ff    <= acc_in;
         addr_ff   <= addr_in;
         wd_ff     <= wd_in;
         fetch_ff  <= fetch_in;
         done_ff   <= done_in;
         states_ff <= states_in;
         rflags_ff <= flags_in;
         rpc_ff    <= rpc_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_access           = acc_ff;
   assign rsp_address          = addr_ff;
   assign rsp_write_data       = wd_ff;
   assign rsp_opcode_fetch     = fetch_ff;
   assign rsp_instruction_done = done_ff;
   assign rsp_states_used      = states_ff;
   assign rsp_condition_flags  = rflags_ff;
   assign rsp_program_counter  = rpc_ff;

endmodule

FILE: design/eacc_checker.sv
// ----------------------------------------------------------------------------
// eacc_checker: port-level checks for the cpu core
// Watches handshake and response consistency at the top-level ports.
// ----------------------------------------------------------------------------
module eacc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_access,
   input logic [13:0] rsp_address,
   input logic [7:0]  rsp_write_data,
   input logic        rsp_opcode_fetch,
   input logic        rsp_instruction_done,
   input logic [3:0]  rsp_states_used
);
   import eacc_pkg::*;

   // response held while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_access))
      else $error("response dropped while stalled");

   // each accepted transaction gives a response next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("missing response");

   // idle reports address zero and no write data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_access == ACC_IDLE |-> rsp_address == 14'd0 && rsp_write_data == 8'd0)
      else $error("idle response not clean");

   // states only reported with instruction end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_instruction_done |-> rsp_states_used == 4'd0)
      else $error("states without instruction end");

   // opcode fetch is a memory read
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_opcode_fetch |-> rsp_access == ACC_MEM_READ)
      else $error("fetch not a read");

endmodule

bind eight_bit_accumulator_cpu_core_top eacc_checker u_eacc_checker (.*);

FILE: bench/tb_eight_bit_accumulator_cpu_core_top.sv
// ----------------------------------------------------------------------------
// tb_eight_bit_accumulator_cpu_core_top: self-checking bench for the cpu core
// Drives bus completions, interrupt jams and resumes that follow the core's
// own bus requests, predicts every response with a behavioral model of the
// core and compares each response transaction field by field.
// ----------------------------------------------------------------------------
module tb_eight_bit_accumulator_cpu_core_top;
   import eacc_pkg::*;

   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic [2:0]  acc;
      logic [13:0] addr;
      logic [7:0]  wdata;
      logic        fetch;
      logic        done;
      logic [3:0]  states;
      logic [3:0]  flags;
      logic [15:0] pc;
   } bus_request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = '0;
   logic [7:0]  req_read_data = '0;
   logic [7:0]  req_jam_first = '0;
   logic [7:0]  req_jam_second = '0;
   logic [7:0]  req_jam_third = '0;
   logic [1:0]  req_jam_count = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_access;
   logic [13:0] rsp_address;
   logic [7:0]  rsp_write_data;
   logic        rsp_opcode_fetch;
   logic        rsp_instruction_done;
   logic [3:0]  rsp_states_used;
   logic [3:0]  rsp_condition_flags;
   logic [15:0] rsp_program_counter;
   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_data = '0;

   eight_bit_accumulator_cpu_core_top uut (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // core model state
   logic [15:0] call_stack [8];
   logic [2:0]  stack_ptr;
   logic [7:0]  regs [7];
   logic [3:0]  flags;
   bit          is_halted;
   logic [7:0]  jam_buf [3];
   int          jam_pos, jam_len;
   bit          jam_live;
   logic [7:0]  cur_op;
   logic [15:0] operand;
   phase_type   phase;
   logic [15:0] break_pc;
   bit          step_mode;
   bit          insn_done;
   logic [3:0]  insn_states;

   bus_request_type pending_requests[$];
   int  mismatches = 0;
   int  items_sent = 0, insns_seen = 0, halts_seen = 0, jams_sent = 0;
   bit  calm = 1'b0;

   function automatic void set_szp(logic [7:0] v);
      flags[3] = ~(^v);
      flags[2] = v[7];
      flags[1] = (v == 8'h00);
   endfunction

   function automatic bit cond_true(logic [2:0] code);
      bit b;
      b = flags[code[1:0]];
      return code[2] ? b : !b;
   endfunction

   function automatic void alu_op(logic [2:0] kind, logic [7:0] s);
      logic [8:0] a9, s9, c9, r;
      a9 = {1'b0, regs[0]};
      s9 = {1'b0, s};
      c9 = {8'h00, flags[0]};
      case (kind)
         3'd0: r = a9 + s9;
         3'd1: r = a9 + s9 + c9;
         3'd2: r = a9 - s9;
         3'd3: r = a9 - s9 - c9;
         3'd4: r = a9 & s9;
         3'd5: r = a9 ^ s9;
         3'd6: r = a9 | s9;
         default: r = a9 - s9;
      endcase
      if (kind != 3'd7) regs[0] = r[7:0];
      set_szp(r[7:0]);
      flags[0] = r[8];
   endfunction

   function automatic void retire(logic [3:0] cyc);
      insn_done = 1'b1;
      insn_states = cyc;
      jam_live = 1'b0;
      if (step_mode) is_halted = 1'b1;
      phase = is_halted ? PH_IDLE : PH_FETCH;
   endfunction

   function automatic void store_result(logic [7:0] v, logic [3:0] cyc);
      logic [2:0] dst;
      dst = cur_op[5:3];
      if (dst == 3'd7) begin
         operand = {8'h00, v};
         phase = PH_MWRITE;
      end else begin
         regs[dst] = v;
         retire(cyc);
      end
   endfunction

   // register ops, rotates, returns, immediates and restarts
   function automatic void exec_group0(logic [7:0] op);
      logic [2:0] low, r;
      logic [7:0] a, nv;
      logic       c, nc;
      low = op[2:0];
      r = op[5:3];
      a = regs[0];
      c = flags[0];
      if (low < 3'd2) begin
         if (r == 3'd0) begin
            is_halted = 1'b1;
            retire(4'd4);
            return;
         end
         // inc/dec of M does nothing
         if (r != 3'd7) begin
            regs[r] = regs[r] + (low[0] ? 8'hFF : 8'h01);
            set_szp(regs[r]);
         end
         retire(4'd5);
      end else if (low == 3'd2) begin
         nv = a;
         nc = c;
         case (op)
            8'o002: begin nv = {a[6:0], a[7]}; nc = a[7]; end
            8'o012: begin nv = {a[0], a[7:1]}; nc = a[0]; end
            8'o022: begin nv = {a[6:0], c}; nc = a[7]; end
            8'o032: begin nv = {c, a[7:1]}; nc = a[0]; end
            default: ;
         endcase
         regs[0] = nv;
         flags[0] = nc;
         retire(4'd5);
      end else if (low[1:0] == 2'd3) begin
         if (op[2] || cond_true(op[5:3])) begin
            stack_ptr = stack_ptr - 3'd1;
            retire(4'd5);
         end else begin
            retire(4'd3);
         end
      end else if (low == 3'd4) begin
         alu_op(r, operand[7:0]);
         retire(4'd8);
      end else if (low == 3'd5) begin
         stack_ptr = stack_ptr + 3'd1;
         call_stack[stack_ptr] = {10'h000, op[5:3], 3'b000};
         retire(4'd5);
      end else begin
         store_result(operand[7:0], 4'd8);
      end
   endfunction

   function automatic void exec_insn();
      logic [7:0] op;
      logic [2:0] src;
      logic [3:0] cyc;
      op = cur_op;
      src = op[2:0];
      case (op[7:6])
         2'd3: begin
            if (op == 8'hFF) begin
               is_halted = 1'b1;
               retire(4'd9);
            end else if (src == 3'd7) phase = PH_MREAD;
            else store_result(regs[src], 4'd5);
         end
         2'd2: begin
            if (src == 3'd7) phase = PH_MREAD;
            else begin
               alu_op(op[5:3], regs[src]);
               retire(4'd5);
            end
         end
         2'd1: begin
            if (op[0]) begin
               phase = (op[5:4] == 2'd0) ? PH_IN : PH_OUT;
            end else begin
               cyc = 4'd9;
               if (op[2] || cond_true(op[5:3])) begin
                  if (op[1]) begin
                     stack_ptr = stack_ptr + 3'd1;
                     cyc = 4'd11;
                  end
                  call_stack[stack_ptr] = operand;
               end
               retire(cyc);
            end
         end
         default: exec_group0(op);
      endcase
   endfunction

   // operands come from the jam while it lasts, then from memory
   function automatic void collect_operands(int have);
      int need;
      need = 0;
      if (cur_op[7:6] == 2'd0 && (cur_op[2:0] == 3'd4 || cur_op[2:0] == 3'd6)) need = 1;
      if (cur_op[7:6] == 2'd1 && !cur_op[0]) need = 2;
      while (have < need) begin
         if (!jam_live || jam_pos >= 3) begin
            phase = (have != 0) ? PH_OPER2 : PH_OPER1;
            return;
         end
         if (have == 0) operand[7:0] = operand[7:0] | jam_buf[jam_pos];
         else operand[15:8] = operand[15:8] | jam_buf[jam_pos];
         jam_pos = (jam_pos + 1) & 3;
         if (jam_pos >= jam_len) jam_live = 1'b0;
         have++;
      end
      exec_insn();
   endfunction

   function automatic void start_insn(logic [7:0] op);
      cur_op = op;
      operand = '0;
      collect_operands(0);
   endfunction

   function automatic void bus_complete(logic [7:0] rd);
      logic [15:0] pc;
      pc = call_stack[stack_ptr];
      case (phase)
         PH_FETCH: begin
            if (pc == break_pc) is_halted = 1'b1;
            call_stack[stack_ptr] = pc + 16'd1;
            start_insn(rd);
         end
         PH_OPER1: begin
            operand[7:0] = operand[7:0] | rd;
            call_stack[stack_ptr] = pc + 16'd1;
            collect_operands(1);
         end
         PH_OPER2: begin
            operand[15:8] = operand[15:8] | rd;
            call_stack[stack_ptr] = pc + 16'd1;
            collect_operands(2);
         end
         PH_MREAD: begin
            if (cur_op[7:6] == 2'd3) store_result(rd, 4'd8);
            else begin
               alu_op(cur_op[5:3], rd);
               retire(4'd8);
            end
         end
         PH_MWRITE: retire((cur_op[7:6] == 2'd3) ? 4'd7 : 4'd9);
         PH_IN: begin
            regs[0] = rd;
            retire(4'd8);
         end
         PH_OUT: retire(4'd5);
         default: ;
      endcase
   endfunction

   // next bus request after one request transaction
   function automatic bus_request_type core_step(logic [1:0] mode, logic [7:0] rd,
                                                 logic [7:0] j0, logic [7:0] j1,
                                                 logic [7:0] j2, logic [1:0] jc);
      bus_request_type q;
      logic [15:0] m;
      insn_done = 1'b0;
      insn_states = '0;
      if (mode == MODE_COMPLETE) begin
         bus_complete(rd);
      end else if (mode == MODE_JAM) begin
         if (phase == PH_IDLE || phase == PH_FETCH) begin
            jam_buf[0] = j0;
            jam_buf[1] = j1;
            jam_buf[2] = j2;
            jam_len = (jc == 2'd0) ? 1 : int'(jc);
            is_halted = 1'b0;
            jam_pos = 1;
            jam_live = (jam_pos < jam_len);
            start_insn(j0);
         end
      end else if (mode == MODE_RESUME) begin
         if (phase == PH_IDLE) begin
            is_halted = 1'b0;
            phase = PH_FETCH;
         end
      end
      m = {regs[5], regs[6]};
      q = '0;
      q.acc = ACC_IDLE;
      case (phase)
         PH_FETCH, PH_OPER1, PH_OPER2: begin
            q.acc = ACC_MEM_READ;
            q.addr = call_stack[stack_ptr][13:0];
         end
         PH_MREAD: begin
            q.acc = ACC_MEM_READ;
            q.addr = m[13:0];
         end
         PH_MWRITE: begin
            q.acc = ACC_MEM_WRITE;
            q.addr = m[13:0];
            q.wdata = operand[7:0];
         end
         PH_IN: begin
            q.acc = ACC_IO_INPUT;
            q.addr = {9'h000, cur_op[5:1]};
         end
         PH_OUT: begin
            q.acc = ACC_IO_OUTPUT;
            q.addr = {9'h000, cur_op[5:1]};
            q.wdata = regs[0];
         end
         default: ;
      endcase
      q.fetch = (phase == PH_FETCH);
      q.done = insn_done;
      q.states = insn_states;
      q.flags = flags;
      q.pc = call_stack[stack_ptr];
      return q;
   endfunction

   function automatic void model_reset();
      foreach (call_stack[i]) call_stack[i] = '0;
      foreach (regs[i]) regs[i] = '0;
      stack_ptr = '0;
      flags = '0;
      is_halted = 1'b1;
      jam_pos = 0;
      jam_len = 0;
      jam_live = 1'b0;
      cur_op = '0;
      operand = '0;
      phase = PH_IDLE;
      break_pc = 16'hFFFF;
      step_mode = 1'b0;
   endfunction

   // response side stalls
   always @(posedge clock)
      rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 24);

   // response checker
   always @(posedge clock) begin
      bus_request_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_access, rsp_address, rsp_write_data, rsp_opcode_fetch,
                rsp_instruction_done, rsp_states_used, rsp_condition_flags,
                rsp_program_counter};
         if (pending_requests.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response transaction %h", got);
         end else begin
            want = pending_requests.pop_front();
            if (got.done) insns_seen++;
            if (got.acc == ACC_IDLE) halts_seen++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: acc %0d/%0d addr %h/%h wd %h/%h fetch %b/%b ",
                           want.acc, got.acc, want.addr, got.addr, want.wdata, got.wdata,
                           want.fetch, got.fetch,
                           "done %b/%b st %0d/%0d fl %h/%h pc %h/%h (exp/act)",
                           want.done, got.done, want.states, got.states,
                           want.flags, got.flags, want.pc, got.pc);
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // send one request transaction and record the predicted response
   task automatic send_request(logic [1:0] mode, logic [7:0] rd, logic [7:0] j0,
                               logic [7:0] j1, logic [7:0] j2, logic [1:0] jc);
      if (!calm && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_read_data <= rd;
      req_jam_first <= j0;
      req_jam_second <= j1;
      req_jam_third <= j2;
      req_jam_count <= jc;
      do @(posedge clock); while (!req_ready);
      pending_requests.push_back(core_step(mode, rd, j0, j1, j2, jc));
      items_sent++;
      if (mode == MODE_JAM) jams_sent++;
   endtask

   // bus completion with the given byte, random don't-care fields
   task automatic reply(logic [7:0] rd);
      send_request(MODE_COMPLETE, rd, 8'($urandom), 8'($urandom), 8'($urandom),
                   2'($urandom));
   endtask

   task automatic jam(logic [7:0] j0, logic [7:0] j1, logic [7:0] j2, logic [1:0] jc);
      send_request(MODE_JAM, 8'($urandom), j0, j1, j2, jc);
   endtask

   task automatic resume();
      send_request(MODE_RESUME, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   2'($urandom));
   endtask

   // hold off until all responses are back and the core has settled
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_requests.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_put(logic idx, logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_BREAKPOINT) break_pc = value;
      else step_mode = value[0];
   endtask

   // opcode stream that rarely halts on its own
   function automatic logic [7:0] pick_opcode();
      logic [7:0] op;
      op = 8'($urandom);
      if ((op == 8'h00 || op == 8'h01 || op == 8'hFF) && $urandom_range(9) != 0)
         op = 8'($urandom);
      return op;
   endfunction

   task automatic test_directed();
      reply(8'h00);                   // completion while halted
      send_request(2'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3);   // reserved mode
      resume();
      reply(8'o006); reply(8'hFF);    // load A immediate 0xff
      reply(8'o004); reply(8'h01);    // add immediate, carry out and zero
      reply(8'o024); reply(8'h80);    // subtract immediate
      reply(8'o002); reply(8'o012); reply(8'o022); reply(8'o032); reply(8'o042);
      reply(8'o010); reply(8'o011); reply(8'o070);            // inc B, dec B, inc M
      send_request(MODE_RESUME, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0); // resume while running
      reply(8'o370); reply(8'h00);    // store A to M
      reply(8'o307); reply(8'h5A);    // load A from M
      reply(8'o106); reply(8'h34);    // call, first operand
      jam(8'hFF, 8'h00, 8'h00, 2'd1); // jam mid-instruction is ignored
      reply(8'h12);
      reply(8'o007);                  // return
      reply(8'o075);                  // restart
      reply(8'o101); reply(8'hC3);    // port input
      reply(8'o121); reply(8'h00);    // port output
      reply(8'o000);                  // inc A halts
      jam(8'o106, 8'hFF, 8'hFF, 2'd3);  // fully jammed call
      jam(8'o104, 8'h00, 8'h00, 2'd0);  // count zero counts as one
      reply(8'h00); reply(8'h00);
      reply(8'hFF);                   // halt
      drain();
   endtask

   task automatic test_random(int count);
      int dice;
      for (int n = 0; n < count; n++) begin
         dice = $urandom_range(99);
         if (phase == PH_IDLE) begin
            if (dice < 78) resume();
            else if (dice < 94) jam(pick_opcode(), 8'($urandom), 8'($urandom), 2'($urandom));
            else send_request(dice[0] ? 2'd3 : MODE_COMPLETE, 8'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom), 2'($urandom));
         end else if (phase == PH_FETCH) begin
            if (dice < 86) reply(pick_opcode());
            else if (dice < 94) jam(pick_opcode(), 8'($urandom), 8'($urandom), 2'($urandom));
            else send_request(dice[0] ? 2'd3 : MODE_RESUME, 8'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom), 2'($urandom));
         end else begin
            if (dice < 90) reply(8'($urandom));
            else send_request(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom), 2'($urandom));
         end
      end
      drain();
   endtask

   task automatic test_main_stream();
      test_random(300);
      calm = 1'b1;
      test_random(150);
      calm = 1'b0;
      test_random(200);
   endtask

   task automatic test_single_step();
      csr_put(CSR_SINGLE_STEP, 16'h0001);
      test_random(120);
      csr_put(CSR_SINGLE_STEP, 16'h0000);
   endtask

   task automatic test_breakpoints();
      csr_put(CSR_BREAKPOINT, 16'h0000);
      test_random(60);
      csr_put(CSR_BREAKPOINT, call_stack[stack_ptr] + 16'($urandom_range(0, 3)));
      test_random(80);
      csr_put(CSR_BREAKPOINT, call_stack[stack_ptr] + 16'd1);
      test_random(60);
      csr_put(CSR_BREAKPOINT, 16'hFFFF);
      test_random(40);
   endtask

   initial begin
      model_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_main_stream();
      test_single_step();
      test_breakpoints();
      $display("run covered %0d request transactions (%0d jams), %0d completed instructions",
               items_sent, jams_sent, insns_seen);
      $display("halted-idle responses seen: %0d, mismatches: %0d", halts_seen, mismatches);
      if (mismatches == 0 && pending_requests.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
